// ===== sv/pixel_upscale_2x_filter_macros.svh =====
// Assertion macros used by the top-level module to check the design.
`ifndef PIXEL_UPSCALE_2X_FILTER_MACROS_SVH
`define PIXEL_UPSCALE_2X_FILTER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PUF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pixel_upscale_2x_filter assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PUF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pixel_upscale_2x_filter assertion failed");

`endif

// ===== sv/puf_pkg.sv =====
`timescale 1ns / 1ps
package puf_pkg;

	localparam int MaxWidthDef  = 1024;
	localparam int MaxHeightDef = 1024;
	localparam int JobDepth     = 4;
	localparam int ResDepth     = 2;
	localparam int CoordW       = 11;
	localparam int CfgW         = 11;

	localparam logic [2:0] ModeDup        = 3'd0;
	localparam logic [2:0] ModeSmooth     = 3'd1;
	localparam logic [2:0] ModeColorscan  = 3'd2;
	localparam logic [2:0] ModeScan50     = 3'd3;
	localparam logic [2:0] ModeColorscan2 = 3'd4;
	localparam logic [2:0] ModeColorscan3 = 3'd5;

	typedef enum logic [1:0] {
		RegMode      = 2'd0,
		RegSrcWidth  = 2'd1,
		RegSrcHeight = 2'd2
	} cfg_reg_t;

	localparam logic [2:0] IdxLastBlock = 3'd3;
	localparam logic [2:0] IdxLastVert  = 3'd5;

	localparam logic [31:0] HalfMask = 32'h00FE_FEFE;
	localparam logic [31:0] MaskB    = 32'h0000_00FF;
	localparam logic [31:0] MaskG    = 32'h0000_FF00;
	localparam logic [31:0] MaskR    = 32'h00FF_0000;
	localparam logic [31:0] MaskRB   = 32'h00FF_00FF;

	function automatic logic [31:0] avg2(logic [31:0] a, logic [31:0] b);
		return ((a & HalfMask) >> 1) + ((b & HalfMask) >> 1);
	endfunction

	// Color of one quadrant of a 2x2 block: 0 top left, 1 top right,
	// 2 bottom left, 3 bottom right.
	function automatic logic [31:0] block_color(logic [2:0] mode, logic [1:0] pos,
			logic [31:0] c, logic [31:0] lc, logic [31:0] nc);
		logic [31:0] tl;
		logic [31:0] tr;
		logic [31:0] bl;
		logic [31:0] br;
		logic [31:0] res;
		unique case (mode)
			ModeSmooth: begin
				tl = c;
				tr = avg2(c, nc);
				bl = c;
				br = tr;
			end
			ModeColorscan: begin
				tl = c & MaskB;
				tr = c & MaskG;
				bl = c & MaskR;
				br = '0;
			end
			ModeScan50: begin
				tl = c;
				tr = c;
				bl = '0;
				br = '0;
			end
			ModeColorscan2: begin
				tl = lc & MaskRB;
				tr = c & MaskG;
				bl = c & MaskG;
				br = nc & MaskRB;
			end
			ModeColorscan3: begin
				tl = (lc & MaskRB) | (c & MaskG);
				tr = c;
				bl = c;
				br = (c & MaskRB) | (nc & MaskG);
			end
			default: begin
				tl = c;
				tr = c;
				bl = c;
				br = c;
			end
		endcase
		case (pos)
			2'd0:    res = tl;
			2'd1:    res = tr;
			2'd2:    res = bl;
			default: res = br;
		endcase
		return res;
	endfunction

endpackage

// ===== sv/puf_fifo.sv =====
`timescale 1ns / 1ps
module puf_fifo #(
	parameter int W     = 1,
	parameter int DEPTH = puf_pkg::ResDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty,
	output logic         full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] ptr_next(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== sv/puf_front.sv =====
`timescale 1ns / 1ps
module puf_front #(
	parameter int MAX_WIDTH  = puf_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = puf_pkg::MaxHeightDef,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [puf_pkg::CfgW-1:0] src_width,
	input  logic [puf_pkg::CfgW-1:0] src_height,
	input  logic                     restart,
	input  logic                     push,
	output logic                     full,
	input  logic [31:0]              pixel,
	input  logic                     job_full,
	output logic                     job_push,
	output logic [XW-1:0]            job_x,
	output logic [YW-1:0]            job_y,
	output logic [31:0]              job_c,
	output logic [31:0]              job_lc,
	output logic [31:0]              job_nc,
	output logic                     job_pnz,
	output logic                     job_last
);

	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic [31:0]   held_q;
	logic [31:0]   left_q;
	logic          pend_valid_q;
	logic [XW-1:0] pend_x_q;
	logic [YW-1:0] pend_y_q;
	logic [31:0]   pend_c_q;
	logic [31:0]   pend_lc_q;

	logic [XW-1:0] wm1;
	logic [YW-1:0] hm1;
	logic          accept;
	logic          has_a;
	logic          last_col;
	logic [31:0]   b_lc;

	always_comb begin
		if (src_width == '0) begin
			wm1 = '0;
		end else if (32'(src_width) > 32'(MAX_WIDTH)) begin
			wm1 = XW'(MAX_WIDTH - 1);
		end else begin
			wm1 = XW'(src_width - puf_pkg::CfgW'(1));
		end
		if (src_height == '0) begin
			hm1 = '0;
		end else if (32'(src_height) > 32'(MAX_HEIGHT)) begin
			hm1 = YW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = YW'(src_height - puf_pkg::CfgW'(1));
		end
	end

	assign full     = pend_valid_q || job_full;
	assign accept   = push && !full;
	assign has_a    = (col_q != '0);
	assign last_col = (col_q == wm1);
	assign b_lc     = has_a ? held_q : '0;

	// A pixel at the end of a row of more than one pixel finishes two blocks; the second one waits here.
	always_comb begin
		if (pend_valid_q) begin
			job_push = !job_full;
			job_x    = pend_x_q;
			job_y    = pend_y_q;
			job_c    = pend_c_q;
			job_lc   = pend_lc_q;
			job_nc   = '0;
			job_pnz  = 1'b1;
			job_last = 1'b1;
		end else if (has_a) begin
			job_push = accept;
			job_x    = col_q - XW'(1);
			job_y    = row_q;
			job_c    = held_q;
			job_lc   = left_q;
			job_nc   = pixel;
			job_pnz  = 1'b0;
			job_last = !last_col;
		end else begin
			job_push = accept && last_col;
			job_x    = col_q;
			job_y    = row_q;
			job_c    = pixel;
			job_lc   = b_lc;
			job_nc   = '0;
			job_pnz  = 1'b1;
			job_last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_x_q  <= col_q;
			pend_y_q  <= row_q;
			pend_c_q  <= pixel;
			pend_lc_q <= b_lc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			held_q       <= '0;
			left_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (restart) begin
			col_q        <= '0;
			row_q        <= '0;
			held_q       <= '0;
			left_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pend_valid_q && !job_full) begin
				pend_valid_q <= 1'b0;
			end
			if (accept) begin
				pend_valid_q <= has_a && last_col;
				if (last_col) begin
					col_q  <= '0;
					held_q <= '0;
					left_q <= '0;
					row_q  <= (row_q == hm1) ? '0 : row_q + YW'(1);
				end else begin
					col_q  <= col_q + XW'(1);
					held_q <= pixel;
					left_q <= b_lc;
				end
			end
		end
	end

endmodule

// ===== sv/puf_back.sv =====
`timescale 1ns / 1ps
module puf_back #(
	parameter int MAX_WIDTH  = puf_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = puf_pkg::MaxHeightDef,
	localparam int XW = $clog2(MAX_WIDTH),
	localparam int YW = $clog2(MAX_HEIGHT)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [2:0]                 mode,
	input  logic                       job_empty,
	output logic                       job_pop,
	input  logic [XW-1:0]              job_x,
	input  logic [YW-1:0]              job_y,
	input  logic [31:0]                job_c,
	input  logic [31:0]                job_lc,
	input  logic [31:0]                job_nc,
	input  logic                       job_pnz,
	input  logic                       job_last,
	input  logic                       res_full,
	output logic                       res_push,
	output logic [puf_pkg::CoordW-1:0] res_x,
	output logic [puf_pkg::CoordW-1:0] res_y,
	output logic [31:0]                res_color,
	output logic                       res_last
);

	logic [23:0]   line_mem_q [MAX_WIDTH];
	logic          job_valid_q;
	logic [2:0]    idx_q;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [31:0]   c_q;
	logic [31:0]   lc_q;
	logic [31:0]   nc_q;
	logic          pnz_q;
	logic          last_q;
	logic [23:0]   p_q;
	logic [23:0]   pn_q;

	logic [XW-1:0] nx;
	logic          vert;
	logic [2:0]    final_idx;
	logic          emit;
	logic          done;
	logic          take;
	logic [31:0]   p32;
	logic [31:0]   pnv;
	logic [31:0]   tr;
	logic [31:0]   pt;
	logic [XW:0]   dx;
	logic [YW:0]   dy;

	assign nx        = job_x + XW'(1);
	assign vert      = (mode == puf_pkg::ModeSmooth) && (y_q != '0);
	assign final_idx = vert ? puf_pkg::IdxLastVert : puf_pkg::IdxLastBlock;
	assign emit      = job_valid_q && !res_full;
	assign done      = emit && (idx_q == final_idx);
	assign take      = !job_empty && (!job_valid_q || done);
	assign job_pop   = take;

	// The line store is read and then overwritten at the cycle a block is taken.
	always_ff @(posedge clk) begin
		if (take) begin
			line_mem_q[job_x] <= job_c[23:0];
			p_q               <= line_mem_q[job_x];
			pn_q              <= line_mem_q[nx];
			x_q               <= job_x;
			y_q               <= job_y;
			c_q               <= job_c;
			lc_q              <= job_lc;
			nc_q              <= job_nc;
			pnz_q             <= job_pnz;
			last_q            <= job_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			job_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (done) begin
			job_valid_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_comb begin
		p32 = {8'h00, p_q};
		pnv = pnz_q ? '0 : {8'h00, pn_q};
		tr  = puf_pkg::avg2(c_q, nc_q);
		pt  = puf_pkg::avg2(p32, pnv);
		dx  = {x_q, idx_q[0]};
		if (idx_q < 3'd2) begin
			dy = {y_q, 1'b0};
		end else if (idx_q < 3'd4) begin
			dy = {y_q, 1'b1};
		end else begin
			dy = {y_q - YW'(1), 1'b1};
		end
		if (idx_q == 3'd4) begin
			res_color = puf_pkg::avg2(p32, c_q);
		end else if (idx_q == 3'd5) begin
			res_color = puf_pkg::avg2(pt, tr);
		end else begin
			res_color = puf_pkg::block_color(mode, idx_q[1:0], c_q, lc_q, nc_q);
		end
	end

	assign res_push = emit;
	assign res_x    = puf_pkg::CoordW'(dx);
	assign res_y    = puf_pkg::CoordW'(dy);
	assign res_last = last_q && (idx_q == final_idx);

endmodule

// ===== sv/pixel_upscale_2x_filter.sv =====
// Channel   Handshake             Payload
// input     push / full           pixel
// result    pop / empty           out_x, out_y, color, last
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each source pixel becomes one 2x2 block of four writes, or six in smooth mode on rows below
// the first; the pixel closing a row finishes two blocks. The back sequencer issues one write a
// cycle while the result queue has room. Pixels enter one a cycle while the block queue has room;
// full stays high after a pixel that closes a row of more than one pixel until its second block
// enters the block queue. Reset is asynchronous; the line store is not cleared. When pop stays
// low the result queue fills, the back sequencer holds, the block queue fills and full rises.
`timescale 1ns / 1ps
`include "pixel_upscale_2x_filter_macros.svh"
module pixel_upscale_2x_filter #(
	parameter int MAX_WIDTH  = puf_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT = puf_pkg::MaxHeightDef
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [31:0]                pixel,
	output logic                       empty,
	input  logic                       pop,
	output logic [puf_pkg::CoordW-1:0] out_x,
	output logic [puf_pkg::CoordW-1:0] out_y,
	output logic [31:0]                color,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [puf_pkg::CfgW-1:0]   cfg_data
);

	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int YW   = $clog2(MAX_HEIGHT);
	localparam int JW   = XW + YW + 32 * 3 + 2;
	localparam int RW   = 2 * puf_pkg::CoordW + 32 + 1;

	logic [2:0]               mode_q;
	logic [puf_pkg::CfgW-1:0] src_width_q;
	logic [puf_pkg::CfgW-1:0] src_height_q;
	logic                     cfg_wr;
	logic                     restart;

	logic          job_push;
	logic [XW-1:0] job_x;
	logic [YW-1:0] job_y;
	logic [31:0]   job_c;
	logic [31:0]   job_lc;
	logic [31:0]   job_nc;
	logic          job_pnz;
	logic          job_last;
	logic          job_full;
	logic          job_empty;
	logic          job_pop;
	logic [JW-1:0] job_rd;

	logic [XW-1:0] q_x;
	logic [YW-1:0] q_y;
	logic [31:0]   q_c;
	logic [31:0]   q_lc;
	logic [31:0]   q_nc;
	logic          q_pnz;
	logic          q_last;

	logic                       res_push;
	logic                       res_full;
	logic [puf_pkg::CoordW-1:0] res_x;
	logic [puf_pkg::CoordW-1:0] res_y;
	logic [31:0]                res_color;
	logic                       res_last;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr && (cfg_index == puf_pkg::RegSrcWidth
		|| cfg_index == puf_pkg::RegSrcHeight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= puf_pkg::ModeDup;
			src_width_q  <= puf_pkg::CfgW'(1024);
			src_height_q <= puf_pkg::CfgW'(1024);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				puf_pkg::RegMode:      mode_q       <= cfg_data[2:0];
				puf_pkg::RegSrcWidth:  src_width_q  <= cfg_data;
				puf_pkg::RegSrcHeight: src_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	puf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_width  (src_width_q),
		.src_height (src_height_q),
		.restart    (restart),
		.push       (push),
		.full       (full),
		.pixel      (pixel),
		.job_full   (job_full),
		.job_push   (job_push),
		.job_x      (job_x),
		.job_y      (job_y),
		.job_c      (job_c),
		.job_lc     (job_lc),
		.job_nc     (job_nc),
		.job_pnz    (job_pnz),
		.job_last   (job_last)
	);

	puf_fifo #(
		.W     (JW),
		.DEPTH (puf_pkg::JobDepth)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data ({job_x, job_y, job_c, job_lc, job_nc, job_pnz, job_last}),
		.rd_en   (job_pop),
		.rd_data (job_rd),
		.empty   (job_empty),
		.full    (job_full)
	);

	assign {q_x, q_y, q_c, q_lc, q_nc, q_pnz, q_last} = job_rd;

	puf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job_x     (q_x),
		.job_y     (q_y),
		.job_c     (q_c),
		.job_lc    (q_lc),
		.job_nc    (q_nc),
		.job_pnz   (q_pnz),
		.job_last  (q_last),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_x     (res_x),
		.res_y     (res_y),
		.res_color (res_color),
		.res_last  (res_last)
	);

	puf_fifo #(
		.W     (RW),
		.DEPTH (puf_pkg::ResDepth)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data ({res_x, res_y, res_color, res_last}),
		.rd_en   (pop && !empty),
		.rd_data ({out_x, out_y, color, last}),
		.empty   (empty),
		.full    (res_full)
	);

	`PUF_ASSERT_IMPL(a_job_pop_nonempty, job_pop, !job_empty)
	`PUF_ASSERT_IMPL(a_res_push_room, res_push, !res_full)
	`PUF_ASSERT_IMPL(a_ready_has_room, !full, !job_full)
	`PUF_ASSERT_NEXT(a_res_push_shows, res_push && !pop, !empty)

endmodule
